// ===== rtl/core/ppnl_pkg.sv =====
// Package for the pixel posterizer: lane count, pipeline depth, config struct
// and the reciprocal table used to divide by the level spacing denominator.
// No dependencies.
`default_nettype none

package ppnl_pkg;

   localparam int LANES       = 3;    // channels processed in color mode, 1..3
   localparam int FIELD_COUNT = 3;    // channel fields per word
   localparam int MAX_LEVELS  = 256;
   localparam int LANE_STAGES = 5;    // register stages inside one lane
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [8:0] LEVELS_RESET = 9'd9;
   localparam logic       COLOR_RESET  = 1'b1;

   typedef enum logic {
      CSR_LEVEL_COUNT = 1'b0,
      CSR_COLOR_MODE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         den;     // levels - 1, 1..255
      logic [RECIP_W-1:0] recip;   // ceil(2^24 / den)
   } cfg_type;

   typedef logic [RECIP_W-1:0] recip_table_type [256];

   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      t[0] = '0;
      for (int i = 1; i < 256; i++) begin
         t[i] = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(i) - 64'd1) / 64'(i));
      end
      return t;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

   // Saturate the written level count to 2..MAX_LEVELS and return count - 1.
   function automatic logic [7:0] level_den(input logic [8:0] count);
      logic [8:0] n;
      n = count;
      if (n < 9'd2) begin
         n = 9'd2;
      end
      if (n > 9'(MAX_LEVELS)) begin
         n = 9'(MAX_LEVELS);
      end
      return 8'(n - 9'd1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppnl_lane.sv =====
// One posterizer lane: maps an 8-bit sample to the nearest uniform level.
// Five register stages, no stall. Depends on ppnl_pkg.
`default_nettype none

module ppnl_lane (
   input  wire logic             clock,
   input  wire ppnl_pkg::cfg_type cfg,
   input  wire logic [7:0]       sample,
   output logic [7:0]            level
);
   import ppnl_pkg::*;

   logic [15:0] prod_in, prod_ff;
   logic [7:0]  s1_ff, s2_ff, s3_ff, s4_ff;
   logic [15:0] lo_sum;
   logic [7:0]  lo_in, lo_ff;
   logic [15:0] n_lo_in, n_lo_ff, n_hi_in, n_hi_ff;
   logic        has_hi_in, has_hi3_ff, has_hi4_ff;
   logic [40:0] mul_lo, mul_hi;
   logic [7:0]  v_lo_in, v_lo_ff, v_hi_in, v_hi_ff;
   logic [8:0]  d_lo, d_hi;
   logic [7:0]  level_in, level_ff;

   // stage 1: sample * den
   assign prod_in = 16'(sample) * 16'(cfg.den);

   // stage 2: lo = floor(prod / 255), exact for prod <= 255*255
   assign lo_sum = prod_ff + {8'b0, prod_ff[15:8]} + 16'd1;
   assign lo_in  = lo_sum[15:8];

   // stage 3: numerators of the ceiling divisions for levels lo and lo+1
   assign n_lo_in   = {lo_ff, 8'b0} - {8'b0, lo_ff} + {8'b0, cfg.den} - 16'd1;
   assign n_hi_in   = n_lo_in + 16'd255;
   assign has_hi_in = (lo_ff != cfg.den);

   // stage 4: divide by den through the reciprocal
   assign mul_lo  = 41'(n_lo_ff) * 41'(cfg.recip);
   assign mul_hi  = 41'(n_hi_ff) * 41'(cfg.recip);
   assign v_lo_in = mul_lo[RECIP_SHIFT+7:RECIP_SHIFT];
   assign v_hi_in = mul_hi[RECIP_SHIFT+7:RECIP_SHIFT];

   // stage 5: pick the nearer level, tie to the lower one
   assign d_lo = {1'b0, s4_ff} - {1'b0, v_lo_ff};
   assign d_hi = {1'b0, v_hi_ff} - {1'b0, s4_ff};
   always_comb begin
      level_in = v_lo_ff;
      if (has_hi4_ff && (d_hi < d_lo)) begin
         level_in = v_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      s1_ff      <= sample;
      lo_ff      <= lo_in;
      s2_ff      <= s1_ff;
      n_lo_ff    <= n_lo_in;
      n_hi_ff    <= n_hi_in;
      has_hi3_ff <= has_hi_in;
      s3_ff      <= s2_ff;
      v_lo_ff    <= v_lo_in;
      v_hi_ff    <= v_hi_in;
      has_hi4_ff <= has_hi3_ff;
      s4_ff      <= s3_ff;
      level_ff   <= level_in;
   end

   assign level = level_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ppnl_merge.sv =====
// Merge stage: gathers the lane levels into one result word, zeroes the
// unused channels in grayscale mode and drives the strobe. Depends on ppnl_pkg.
`default_nettype none

module ppnl_merge (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       valid,
   input  wire logic       color_mode,
   input  wire logic [7:0] lane_level [ppnl_pkg::FIELD_COUNT],
   output logic            out_valid,
   output logic [7:0]      out_level [ppnl_pkg::FIELD_COUNT]
);
   import ppnl_pkg::*;

   logic       valid_ff;
   logic [7:0] level_in [FIELD_COUNT];
   logic [7:0] level_ff [FIELD_COUNT];

   always_comb begin
      for (int c = 0; c < FIELD_COUNT; c++) begin
         level_in[c] = (c == 0 || color_mode) ? lane_level[c] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign out_valid = valid_ff;
   assign out_level = level_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_posterize_nearest_level.sv =====
// Pixel posterizer top level: config registers, lanes, merge stage.
// Depends on ppnl_pkg, ppnl_lane, ppnl_merge.
//
// Usage:
//   Input words: raise start with req_sample_c0..c2; the word is taken at a
//   clock edge where start is high and busy is low. busy is high only during
//   reset, so a new pixel can be taken every cycle.
//   Results: rsp_valid pulses for one cycle with rsp_out_c0..c2 once the
//   word has left the merge register. Throughput is one pixel per clock:
//   each channel has its own five-stage lane (multiply, divide by 255, level
//   numerators, reciprocal multiply, nearest pick) plus one shared merge
//   register. The receiver cannot stall; results are never held back.
//   Config: csr_write_en, csr_index, csr_wdata write level_count (index 0)
//   or color_mode (index 1). Write only while no pixel is in flight.
//   Reset: synchronous; clears the pipeline, level_count = 9, color_mode = 1.
`default_nettype none

module pixel_posterize_nearest_level (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_sample_c0,
   input  wire logic [7:0] req_sample_c1,
   input  wire logic [7:0] req_sample_c2,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_c0,
   output logic [7:0]      rsp_out_c1,
   output logic [7:0]      rsp_out_c2,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata
);
   import ppnl_pkg::*;

   cfg_type                cfg_in, cfg_ff;
   logic                   color_mode_in, color_mode_ff;
   logic [LANE_STAGES-1:0] valid_in, valid_ff;
   logic                   accept;
   logic [7:0]             sample [FIELD_COUNT];
   logic [7:0]             lane_level [FIELD_COUNT];
   logic [7:0]             out_level [FIELD_COUNT];

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in        = cfg_ff;
      color_mode_in = color_mode_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_LEVEL_COUNT: begin
               cfg_in.den   = level_den(csr_wdata);
               cfg_in.recip = RECIP_TABLE[level_den(csr_wdata)];
            end
            CSR_COLOR_MODE: begin
               color_mode_in = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign valid_in = {valid_ff[LANE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.den    <= level_den(LEVELS_RESET);
         cfg_ff.recip  <= RECIP_TABLE[level_den(LEVELS_RESET)];
         color_mode_ff <= COLOR_RESET;
         valid_ff      <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         color_mode_ff <= color_mode_in;
         valid_ff      <= valid_in;
      end
   end

   assign sample[0] = req_sample_c0;
   assign sample[1] = req_sample_c1;
   assign sample[2] = req_sample_c2;

   for (genvar c = 0; c < FIELD_COUNT; c++) begin : g_lane
      if (c < LANES) begin : g_on
         ppnl_lane u_lane (
            .clock  (clock),
            .cfg    (cfg_ff),
            .sample (sample[c]),
            .level  (lane_level[c])
         );
      end else begin : g_off
         assign lane_level[c] = 8'd0;
      end
   end

   ppnl_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid      (valid_ff[LANE_STAGES-1]),
      .color_mode (color_mode_ff),
      .lane_level (lane_level),
      .out_valid  (rsp_valid),
      .out_level  (out_level)
   );

   assign rsp_out_c0 = out_level[0];
   assign rsp_out_c1 = out_level[1];
   assign rsp_out_c2 = out_level[2];

   // a result word only ever follows an accepted word by the full latency
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LANE_STAGES + 1))
      else $error("result strobe without matching input word");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LANE_STAGES + 1) (rsp_valid || $past(reset, LANE_STAGES)
         || $past(reset, LANE_STAGES - 1) || $past(reset, LANE_STAGES - 2)
         || $past(reset, LANE_STAGES - 3) || $past(reset, LANE_STAGES - 4)
         || $past(reset, 1)))
      else $error("accepted word produced no result");

   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !color_mode_ff) |-> (rsp_out_c1 == 8'd0 && rsp_out_c2 == 8'd0))
      else $error("grayscale result has nonzero color channels");

   a_den_range: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.den != 8'd0)
      else $error("level denominator saturated to zero");

endmodule

`default_nettype wire

// ===== bench/tb_pixel_posterize_nearest_level.sv =====
// Self-checking bench for pixel_posterize_nearest_level: directed vector table, then random
// pixels under several level counts and color modes, each result checked against a predictor.
// Depends on ppnl_pkg and the pixel_posterize_nearest_level RTL.
`default_nettype none

module tb_pixel_posterize_nearest_level;
   import ppnl_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int PIPE_LATENCY = 6;
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 800;
   localparam int SEGMENTS     = 12;   // 3 idle phases x 4 register settings
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_VECTORS  = 22;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } pixel_type;

   typedef struct packed {
      logic [8:0] levels;
      logic       color;
      pixel_type  sample;
      logic       typed;    // result below is typed in, else predicted
      pixel_type  result;
   } vector_type;

   // Tie cases: a sample midway between two levels goes to the lower one.
   localparam vector_type DIRECTED [NUM_VECTORS] = '{
      '{9'd9,   1'b1, '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{9'd9,   1'b1, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{9'd9,   1'b1, '{8'd16,  8'd15,  8'd17 }, 1'b1, '{8'd0,   8'd0,   8'd32 }},
      '{9'd9,   1'b1, '{8'd48,  8'd112, 8'd240}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd3,   1'b1, '{8'd64,  8'd191, 8'd192}, 1'b1, '{8'd0,   8'd128, 8'd255}},
      '{9'd3,   1'b1, '{8'd128, 8'd127, 8'd129}, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{9'd2,   1'b1, '{8'd127, 8'd128, 8'd255}, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{9'd2,   1'b0, '{8'd128, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
      '{9'd2,   1'b0, '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{9'd0,   1'b1, '{8'd127, 8'd128, 8'd1  }, 1'b1, '{8'd0,   8'd255, 8'd0  }},
      '{9'd1,   1'b0, '{8'd200, 8'd100, 8'd50 }, 1'b1, '{8'd255, 8'd0,   8'd0  }},
      '{9'd256, 1'b1, '{8'hAA,  8'h55,  8'h01 }, 1'b1, '{8'hAA,  8'h55,  8'h01 }},
      '{9'd256, 1'b0, '{8'h7F,  8'hFF,  8'hFF }, 1'b1, '{8'h7F,  8'h00,  8'h00 }},
      '{9'd511, 1'b1, '{8'h80,  8'hFE,  8'h33 }, 1'b1, '{8'h80,  8'hFE,  8'h33 }},
      '{9'd257, 1'b1, '{8'h00,  8'hFF,  8'h5A }, 1'b1, '{8'h00,  8'hFF,  8'h5A }},
      '{9'd4,   1'b1, '{8'd42,  8'd43,  8'd127}, 1'b1, '{8'd0,   8'd85,  8'd85 }},
      '{9'd4,   1'b1, '{8'd128, 8'd212, 8'd213}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd7,   1'b1, '{8'd21,  8'd22,  8'd64 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd128, 1'b1, '{8'd1,   8'd254, 8'd127}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd255, 1'b1, '{8'h0F,  8'hF0,  8'h81 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd100, 1'b0, '{8'h3C,  8'hC3,  8'h99 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{9'd9,   1'b1, '{8'h55,  8'hAA,  8'h66 }, 1'b0, '{8'd0,   8'd0,   8'd0  }}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_sample_c0 = '0;
   logic [7:0] req_sample_c1 = '0;
   logic [7:0] req_sample_c2 = '0;
   logic       rsp_valid;
   logic [7:0] rsp_out_c0;
   logic [7:0] rsp_out_c1;
   logic [7:0] rsp_out_c2;
   logic       csr_write_en = 1'b0;
   logic       csr_index = CSR_LEVEL_COUNT;
   logic [8:0] csr_wdata = '0;

   pixel_type  posterized_q [$];
   logic [8:0] levels_reg = LEVELS_RESET;
   logic       color_reg  = COLOR_RESET;
   int         idle_pct;
   int         error_count;
   int         pixels_sent;
   int         pixels_checked;
   int         settings_count;
   int         stall_cycles = 0;

   pixel_posterize_nearest_level uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_sample_c0 (req_sample_c0),
      .req_sample_c1 (req_sample_c1),
      .req_sample_c2 (req_sample_c2),
      .rsp_valid     (rsp_valid),
      .rsp_out_c0    (rsp_out_c0),
      .rsp_out_c1    (rsp_out_c1),
      .rsp_out_c2    (rsp_out_c2),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------- predictor ----------------

   // Written count saturates into 2..MAX_LEVELS.
   function automatic int clamp_levels(input logic [8:0] written);
      int n;
      n = written;
      if (n < 2) begin
         n = 2;
      end
      if (n > MAX_LEVELS) begin
         n = MAX_LEVELS;
      end
      return n;
   endfunction

   // ceil(i * 255 / (n - 1))
   function automatic int level_value(input int i, input int n);
      return (i * 255 + n - 2) / (n - 1);
   endfunction

   function automatic logic [7:0] nearest_level_value(input logic [7:0] sample, input int n);
      int best_gap;
      int best;
      int s;
      int v;
      int gap;
      best_gap = 1 << 20;
      best = 0;
      s = sample;
      for (int i = 0; i < n; i++) begin
         v = level_value(i, n);
         gap = (s > v) ? s - v : v - s;
         if (gap < best_gap) begin    // strict: ties keep the lower level
            best_gap = gap;
            best = v;
         end
      end
      return 8'(best);
   endfunction

   function automatic pixel_type posterize(input pixel_type px);
      pixel_type r;
      int n;
      n = clamp_levels(levels_reg);
      r = '0;
      r.c0 = nearest_level_value(px.c0, n);
      if (color_reg && LANES > 1) begin
         r.c1 = nearest_level_value(px.c1, n);
      end
      if (color_reg && LANES > 2) begin
         r.c2 = nearest_level_value(px.c2, n);
      end
      return r;
   endfunction

   // ---------------- stimulus ----------------

   // Bias samples toward level midpoints so ties and near-ties show up often.
   function automatic logic [7:0] pick_sample();
      int n;
      int i;
      int m;
      n = clamp_levels(levels_reg);
      case ($urandom_range(0, 3))
         0, 1: begin
            return 8'($urandom);
         end
         2: begin
            i = $urandom_range(0, n - 2);
            m = (level_value(i, n) + level_value(i + 1, n)) / 2 + $urandom_range(0, 2) - 1;
            if (m < 0) begin
               m = 0;
            end
            if (m > 255) begin
               m = 255;
            end
            return 8'(m);
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            return 8'(level_value($urandom_range(0, n - 1), n));
         end
      endcase
   endfunction

   function automatic logic [8:0] pick_levels();
      case ($urandom_range(0, 7))
         0: return 9'($urandom_range(0, 1));
         1: return 9'd2;
         2: return 9'($urandom_range(3, 16));
         5: return 9'(MAX_LEVELS);
         6: return 9'($urandom_range(257, 510));
         7: return 9'd511;
         default: return 9'($urandom_range(2, 256));
      endcase
   endfunction

   // Each cycle the sender stays idle with probability idle_pct.
   task automatic send_pixel(input pixel_type px, input logic typed, input pixel_type given);
      pixel_type want;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      want = typed ? given : posterize(px);
      start         <= 1'b1;
      req_sample_c0 <= px.c0;
      req_sample_c1 <= px.c1;
      req_sample_c2 <= px.c2;
      do @(posedge clock); while (busy);
      posterized_q = {posterized_q, want};
      pixels_sent++;
   endtask

   // Stop sending and let the pipeline empty out.
   task automatic drain();
      start <= 1'b0;
      while (posterized_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Both registers every time; spare bits of the color write carry junk.
   task automatic set_config(input logic [8:0] levels, input logic color);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_LEVEL_COUNT;
      csr_wdata    <= levels;
      @(posedge clock);
      csr_index    <= CSR_COLOR_MODE;
      csr_wdata    <= {8'($urandom), color};
      @(posedge clock);
      csr_write_en <= 1'b0;
      levels_reg = levels;
      color_reg  = color;
      settings_count++;
   endtask

   initial begin
      pixel_type px;
      int per_segment;
      error_count    = 0;
      pixels_sent    = 0;
      pixels_checked = 0;
      settings_count = 0;
      idle_pct       = 28;
      per_segment    = RANDOM_ITEMS / SEGMENTS;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; opening rows run on the reset register values
      for (int k = 0; k < NUM_VECTORS; k++) begin
         if (DIRECTED[k].levels != levels_reg || DIRECTED[k].color != color_reg) begin
            drain();
            set_config(DIRECTED[k].levels, DIRECTED[k].color);
         end
         send_pixel(DIRECTED[k].sample, DIRECTED[k].typed, DIRECTED[k].result);
      end

      // random: sender idles 28%, then 60%, then never
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct = (seg < 4) ? 28 : (seg < 8) ? 60 : 0;
         drain();
         set_config(pick_levels(), 1'($urandom_range(0, 1)));
         for (int k = 0; k < per_segment; k++) begin
            px.c0 = pick_sample();
            px.c1 = pick_sample();
            px.c2 = pick_sample();
            send_pixel(px, 1'b0, '0);
         end
      end

      drain();
      $display("Sent %0d pixels over %0d register settings, %0d results checked.",
               pixels_sent, settings_count, pixels_checked);
      $display("Level counts from 0 to 511, both color modes, ties and sender gaps covered.");
      if (error_count == 0 && posterized_q.size() == 0) begin
         $display("tb_pixel_posterize_nearest_level: done, clean");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, posterized_q.size());
         $display("tb_pixel_posterize_nearest_level: done, errors");
      end
      $finish;
   end

   // ---------------- checking ----------------

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (posterized_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("unexpected result word %h %h %h", rsp_out_c0, rsp_out_c1, rsp_out_c2);
            end
         end else begin
            want = posterized_q.pop_front();
            pixels_checked++;
            if (rsp_out_c0 !== want.c0 || rsp_out_c1 !== want.c1 || rsp_out_c2 !== want.c2) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("result %0d mismatch: expected %h %h %h, got %h %h %h",
                           pixels_checked, want.c0, want.c1, want.c2,
                           rsp_out_c0, rsp_out_c1, rsp_out_c2);
               end
            end
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no activity for %0d cycles", STALL_LIMIT);
         $display("tb_pixel_posterize_nearest_level: done, errors");
         $finish;
      end
   end

endmodule

`default_nettype wire
